>>> sv/urx_pkg.sv
package urx_pkg;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_BIT_PERIOD = 2'd0;
    localparam logic [1:0] REG_HALF_BIT   = 2'd1;
    localparam logic [1:0] REG_TIMEOUT    = 2'd2;

    // Port widths
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 24;
    localparam int IN_W      = 8;
    localparam int OUT_W     = 16;

    // Register reset values
    localparam logic [23:0] BIT_PERIOD_RST = 24'd868;
    localparam logic [22:0] HALF_BIT_RST   = 23'd434;
    localparam logic [23:0] TIMEOUT_RST    = 24'd1000000;

    // Saturation limit of the elapsed tick counter
    localparam logic [23:0] CNT_MAX = 24'hFFFFFF;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_TIMEOUT = 2'd1,
        ST_FRAME   = 2'd2
    } status_t;

    typedef struct packed {
        logic [23:0] bit_period;
        logic [22:0] half_bit_period;
        logic [23:0] timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic        valid;
        status_t     status;
        logic [7:0]  data_byte;
    } result_t;

endpackage

>>> sv/uart_rx_8n1_timeout_top.sv
// Timed asynchronous serial receiver, one byte per read, 8N1 framing.
// Slave stream: one beat per system clock tick with the sampled line level
// and an arm flag. Arming while idle starts a read: the receiver waits for
// the line to go idle high and then for the falling start edge, samples the
// data bits LSB first at mid-bit, then checks the stop bit.
// Master stream: one beat per read with a status (ok, timeout before the
// start edge, stop bit low) and the byte, which is zero unless status is ok.
// Configuration port: bit period, half bit period and timeout in ticks,
// written by the user only while no read is running; the block does not check it.
// A beat is captured in the input register and then processed into the
// result register, which drives master tvalid.
// Throughput: one slave beat every cycle except while stalled as below, set by
// the single-pass tick update between the input register and the result register.
// Stall: while a result waits in the result register, beats that cause no
// result still flow; s_tready drops only when the held beat would produce a
// result while the previous one is still waiting and m_tready is low.
// Reset: registers return to 868, 434 and 1000000 ticks, the receiver is
// idle and not armed, and both stream registers are empty.
module uart_rx_8n1_timeout_top
#(
    parameter int DATA_BITS = 8
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    // slave stream, tdata: arm [0], rx_level [1], zero [7:2]
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [urx_pkg::IN_W-1:0]      s_tdata,
    // master stream, tdata: status [1:0], data_byte [9:2], zero [15:10]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [urx_pkg::OUT_W-1:0]     m_tdata,
    // configuration write port
    input  logic                          cfg_we,
    input  logic [urx_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [urx_pkg::CFG_W-1:0]     cfg_data
);

    urx_pkg::cfg_t    cfg;
    urx_pkg::result_t res;

    logic             in_valid_reg, in_valid_next;
    logic             in_arm_reg;
    logic             in_rx_reg;
    logic             m_valid_reg, m_valid_next;
    urx_pkg::status_t m_status_reg;
    logic [7:0]       m_byte_reg;
    logic             advance;

    urx_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    urx_step #(.DATA_BITS(DATA_BITS)) u_step
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (in_valid_reg),
        .arm        (in_arm_reg),
        .rx_level   (in_rx_reg),
        .advance    (advance),
        .res        (res)
    );

    // Take the held beat unless its result has nowhere to go
    assign advance  = in_valid_reg & (~res.valid | ~m_valid_reg | m_tready);
    assign s_tready = ~in_valid_reg | advance;

    assign in_valid_next = s_tready ? s_tvalid : in_valid_reg;
    assign m_valid_next  = (advance & res.valid) | (m_valid_reg & ~m_tready);

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_arm_reg <= s_tdata[0];
            in_rx_reg  <= s_tdata[1];
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res.valid)
        begin
            m_status_reg <= res.status;
            m_byte_reg   <= res.data_byte;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, m_byte_reg, m_status_reg};

`ifndef SYNTHESIS
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && res.valid && m_valid_reg && !m_tready))
        else $error("input stalled without a blocked result");

    a_error_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_status_reg != urx_pkg::ST_OK) |-> (m_byte_reg == 8'd0))
        else $error("nonzero byte with an error status");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> (m_status_reg == urx_pkg::ST_OK ||
                         m_status_reg == urx_pkg::ST_TIMEOUT ||
                         m_status_reg == urx_pkg::ST_FRAME))
        else $error("result status out of range");
`endif

endmodule

>>> sv/urx_cfg_regs.sv
module urx_cfg_regs
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [urx_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [urx_pkg::CFG_W-1:0]     cfg_data,
    output urx_pkg::cfg_t                 cfg
);

    logic [23:0] bit_period_reg;
    logic [22:0] half_bit_reg;
    logic [23:0] timeout_reg;

    // Write the addressed register; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_period_reg <= urx_pkg::BIT_PERIOD_RST;
            half_bit_reg   <= urx_pkg::HALF_BIT_RST;
            timeout_reg    <= urx_pkg::TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                urx_pkg::REG_BIT_PERIOD: bit_period_reg <= cfg_data[23:0];
                urx_pkg::REG_HALF_BIT:   half_bit_reg   <= cfg_data[22:0];
                urx_pkg::REG_TIMEOUT:    timeout_reg    <= cfg_data[23:0];
                default:                 ;
            endcase
        end
    end

    assign cfg.bit_period      = bit_period_reg;
    assign cfg.half_bit_period = half_bit_reg;
    assign cfg.timeout_ticks   = timeout_reg;

endmodule

>>> sv/urx_step.sv
module urx_step
#(
    parameter int DATA_BITS = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  urx_pkg::cfg_t    cfg,
    input  logic             item_valid,
    input  logic             arm,
    input  logic             rx_level,
    input  logic             advance,
    output urx_pkg::result_t res
);

    localparam int          TOP_POS    = (DATA_BITS < 8) ? DATA_BITS - 1 : 7;
    localparam logic [3:0]  LAST_INDEX = 4'(DATA_BITS);

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_WAIT_HIGH = 3'd1,
        PH_WAIT_FALL = 3'd2,
        PH_HALF      = 3'd3,
        PH_DATA      = 3'd4,
        PH_STOP      = 3'd5
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [23:0] elapsed_reg, elapsed_next;
    logic [23:0] wait_reg, wait_next;
    logic [3:0]  index_reg, index_next;
    logic [7:0]  shift_reg, shift_next;

    logic             produce;
    urx_pkg::status_t status;
    logic [7:0]       byte_out;
    logic [23:0]      elapsed_bump;
    logic             wait_done;
    logic [23:0]      wait_dec;
    logic             timed_out;

    assign elapsed_bump = (elapsed_reg != urx_pkg::CNT_MAX) ? elapsed_reg + 24'd1 : elapsed_reg;
    assign wait_done    = (wait_reg <= 24'd1);
    assign wait_dec     = wait_reg - 24'd1;
    assign timed_out    = (elapsed_reg >= cfg.timeout_ticks);

    // Advance the receive sequence by one tick
    always_comb
    begin
        phase_next   = phase_reg;
        elapsed_next = elapsed_reg;
        wait_next    = wait_reg;
        index_next   = index_reg;
        shift_next   = shift_reg;
        produce      = 1'b0;
        status       = urx_pkg::ST_OK;
        byte_out     = 8'd0;
        case (phase_reg)
            PH_IDLE:
            begin
                if (arm)
                begin
                    phase_next   = PH_WAIT_HIGH;
                    elapsed_next = 24'd0;
                    wait_next    = 24'd0;
                    index_next   = 4'd0;
                    shift_next   = 8'd0;
                end
            end
            PH_WAIT_HIGH, PH_WAIT_FALL:
            begin
                if (phase_reg == PH_WAIT_HIGH && rx_level)
                begin
                    phase_next   = PH_WAIT_FALL;
                    elapsed_next = elapsed_bump;
                end
                else if (phase_reg == PH_WAIT_FALL && !rx_level)
                begin
                    // start edge seen: skip the half period when it is zero
                    index_next = 4'd0;
                    shift_next = 8'd0;
                    if (cfg.half_bit_period == 23'd0)
                    begin
                        phase_next = PH_DATA;
                        wait_next  = cfg.bit_period;
                    end
                    else
                    begin
                        phase_next = PH_HALF;
                        wait_next  = {1'b0, cfg.half_bit_period};
                    end
                end
                else if (timed_out)
                begin
                    phase_next   = PH_IDLE;
                    elapsed_next = 24'd0;
                    wait_next    = 24'd0;
                    index_next   = 4'd0;
                    shift_next   = 8'd0;
                    produce      = 1'b1;
                    status       = urx_pkg::ST_TIMEOUT;
                end
                else
                begin
                    elapsed_next = elapsed_bump;
                end
            end
            PH_HALF:
            begin
                if (wait_done)
                begin
                    phase_next = PH_DATA;
                    wait_next  = cfg.bit_period;
                end
                else
                begin
                    wait_next = wait_dec;
                end
            end
            PH_DATA:
            begin
                if (wait_done)
                begin
                    // shift the sampled bit in from the top, LSB first
                    shift_next = {1'b0, shift_reg[7:1]} | (8'(rx_level) << TOP_POS);
                    index_next = index_reg + 4'd1;
                    wait_next  = cfg.bit_period;
                    if (index_next >= LAST_INDEX)
                    begin
                        phase_next = PH_STOP;
                    end
                end
                else
                begin
                    wait_next = wait_dec;
                end
            end
            PH_STOP:
            begin
                if (wait_done)
                begin
                    phase_next   = PH_IDLE;
                    elapsed_next = 24'd0;
                    wait_next    = 24'd0;
                    index_next   = 4'd0;
                    shift_next   = 8'd0;
                    produce      = 1'b1;
                    if (rx_level)
                    begin
                        status   = urx_pkg::ST_OK;
                        byte_out = shift_reg;
                    end
                    else
                    begin
                        status = urx_pkg::ST_FRAME;
                    end
                end
                else
                begin
                    wait_next = wait_dec;
                end
            end
            default:
            begin
                phase_next   = PH_IDLE;
                elapsed_next = 24'd0;
                wait_next    = 24'd0;
                index_next   = 4'd0;
                shift_next   = 8'd0;
            end
        endcase
    end

    assign res.valid     = item_valid & produce;
    assign res.status    = status;
    assign res.data_byte = byte_out;

    // Hold state unless the current beat is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            elapsed_reg <= 24'd0;
            wait_reg    <= 24'd0;
            index_reg   <= 4'd0;
            shift_reg   <= 8'd0;
        end
        else if (advance)
        begin
            phase_reg   <= phase_next;
            elapsed_reg <= elapsed_next;
            wait_reg    <= wait_next;
            index_reg   <= index_next;
            shift_reg   <= shift_next;
        end
    end

`ifndef SYNTHESIS
    a_result_phase: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (phase_reg == PH_WAIT_HIGH || phase_reg == PH_WAIT_FALL ||
                       phase_reg == PH_STOP))
        else $error("result outside a waiting or stop phase");

    a_idle_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && res.valid) |=> (phase_reg == PH_IDLE && elapsed_reg == 24'd0))
        else $error("receiver not idle after a result");

    a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
        index_reg <= LAST_INDEX)
        else $error("bit index past the data width");
`endif

endmodule
